// ----- rtl/pslk_pkg.sv -----
`default_nettype none

package pslk_pkg;

    // Default field widths.
    localparam int COUNT_BITS_DEF    = 24;
    localparam int POSITION_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Fixed field widths.
    localparam int LIMIT_BITS = 15;
    localparam int SPAN_BITS  = 16;
    localparam int DUR_BITS   = 16;
    localparam int FRAME_CFG_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int FRAME_BITS = 32;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_POSITION_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPAN         = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOCK_DURATION_MS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_FRAMES       = 3'd3;

    // Register reset values.
    localparam logic [LIMIT_BITS-1:0]     POSITION_LIMIT_RST   = 15'd3200;
    localparam logic [SPAN_BITS-1:0]      MAX_SPAN_RST         = 16'd160;
    localparam logic [DUR_BITS-1:0]       LOCK_DURATION_RST    = 16'd500;
    localparam logic [FRAME_CFG_BITS-1:0] MIN_FRAMES_RST       = 16'd10;

endpackage

`default_nettype wire

// ----- rtl/pslk_divider.sv -----
`default_nettype none

// Restoring divider: one quotient bit per cycle shifted through the
// dividend register, remainder kept in a narrow shift register.
module pslk_divider #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_dividend,
    input  wire logic [DEN_BITS-1:0] i_divisor,
    output logic                     o_done,
    output logic [NUM_BITS-1:0]      o_quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;

    logic [DEN_BITS:0]   n_shift;
    logic [DEN_BITS:0]   n_diff;
    logic                n_ge;

    // One trial subtraction per cycle.
    always_comb begin
        n_shift = {r_rem, r_quo[NUM_BITS-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_ge    = (n_shift >= {1'b0, r_den});
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_BITS-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DEN_BITS-1:0] : n_shift[DEN_BITS-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/position_settle_lock_detector_top.sv -----
// A non-locking result passes through the evaluate and emit states into the output register; a
// locking one also passes through the divider start and wait states, waiting on the serial divider.
// Only one item is in flight at a time; the next transfer is taken once the sequencer has left
// the emit state and returned to idle.
// A result waiting in the output register holds the next item in the emit state until it is taken.
// Reset (synchronous, active low) restores register defaults and clears all window state.
`default_nettype none

module position_settle_lock_detector_top #(
    parameter int COUNT_BITS    = pslk_pkg::COUNT_BITS_DEF,
    parameter int POSITION_BITS = pslk_pkg::POSITION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration port.
    input  wire logic                               i_cfg_we,
    input  wire logic [pslk_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [pslk_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // Input channel.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [POSITION_BITS-1:0]    i_position,
    input  wire logic [pslk_pkg::TIME_BITS-1:0]     i_sample_time_ms,
    input  wire logic [pslk_pkg::FRAME_BITS-1:0]    i_frame_number,
    // Output channel.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_lock_status,
    output logic signed [POSITION_BITS-1:0]         o_target_position,
    output logic [pslk_pkg::SPAN_BITS-1:0]          o_window_span
);

    import pslk_pkg::*;

    localparam int SUM_BITS = COUNT_BITS + POSITION_BITS;
    localparam int CMP_BITS = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
    localparam int SPW_BITS = ((POSITION_BITS + 1 > 17) ? POSITION_BITS + 1 : 17);
    localparam int CNW_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [LIMIT_BITS-1:0]     r_position_limit;
    logic [SPAN_BITS-1:0]      r_max_span;
    logic [DUR_BITS-1:0]       r_lock_duration;
    logic [FRAME_CFG_BITS-1:0] r_min_frames;

    // Window state.
    logic [FRAME_BITS-1:0]           r_last_frame;
    logic [TIME_BITS-1:0]            r_start_ms;
    logic [COUNT_BITS-1:0]           r_total;
    logic                            r_open;
    logic signed [SUM_BITS-1:0]      r_sum;
    logic signed [POSITION_BITS-1:0] r_min;
    logic signed [POSITION_BITS-1:0] r_max;
    logic signed [POSITION_BITS-1:0] r_held;
    logic                            r_locked;
    logic                            r_neg;

    // Captured input item.
    logic signed [POSITION_BITS-1:0] r_pos;
    logic [TIME_BITS-1:0]            r_time;
    logic [FRAME_BITS-1:0]           r_frame;

    // Output register.
    logic                            r_out_valid;
    logic                            r_out_lock;
    logic signed [POSITION_BITS-1:0] r_out_target;
    logic [SPAN_BITS-1:0]            r_out_span;

    // Evaluation terms.
    logic                            n_dup;
    logic                            n_oor;
    logic signed [CMP_BITS-1:0]      n_pos_x;
    logic signed [CMP_BITS-1:0]      n_lim_x;
    logic signed [POSITION_BITS-1:0] n_lo;
    logic signed [POSITION_BITS-1:0] n_hi;
    logic [POSITION_BITS:0]          n_span_new;
    logic                            n_span_big;
    logic [TIME_BITS-1:0]            n_elapsed;
    logic                            n_time_ok;
    logic [COUNT_BITS-1:0]           n_total;
    logic signed [SUM_BITS-1:0]      n_sum;
    logic                            n_count_ok;
    logic                            n_lock;
    logic [POSITION_BITS:0]          n_span_cur;
    logic [SPW_BITS-1:0]             n_span_wide;
    logic [SUM_BITS-1:0]             n_sum_mag;
    logic                            n_out_free;

    logic                            w_div_start;
    logic                            w_div_done;
    logic [SUM_BITS-1:0]             w_quotient;

    // Classify the captured sample against the current window.
    always_comb begin
        n_dup      = (r_frame == r_last_frame);
        n_pos_x    = CMP_BITS'(r_pos);
        n_lim_x    = $signed({{(CMP_BITS - LIMIT_BITS){1'b0}}, r_position_limit});
        n_oor      = (n_pos_x < -n_lim_x) || (n_pos_x > n_lim_x);
        n_lo       = (r_pos < r_min) ? r_pos : r_min;
        n_hi       = (r_pos > r_max) ? r_pos : r_max;
        n_span_new = $unsigned($signed({n_hi[POSITION_BITS-1], n_hi})
                               - $signed({n_lo[POSITION_BITS-1], n_lo}));
        n_span_big = SPW_BITS'(n_span_new) > SPW_BITS'(r_max_span);
        n_elapsed  = r_time - r_start_ms;
        n_time_ok  = n_elapsed >= TIME_BITS'(r_lock_duration);
        n_total    = (r_total == '1) ? r_total : r_total + 1'b1;
        n_sum      = (r_total == '1) ? r_sum : r_sum + SUM_BITS'(r_pos);
        n_count_ok = CNW_BITS'(n_total) >= CNW_BITS'(r_min_frames);
        n_lock     = !n_dup && !n_oor && r_open && !n_span_big && n_time_ok && n_count_ok;
    end

    // Span of the settled window and magnitude of the settled sum.
    always_comb begin
        n_span_cur  = $unsigned($signed({r_max[POSITION_BITS-1], r_max})
                                - $signed({r_min[POSITION_BITS-1], r_min}));
        n_span_wide = SPW_BITS'(n_span_cur);
        n_sum_mag   = r_sum[SUM_BITS-1] ? $unsigned(-r_sum) : $unsigned(r_sum);
        n_out_free  = !r_out_valid || i_out_ready;
    end

    assign w_div_start = (r_state == ST_DIV_START);

    pslk_divider #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (COUNT_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum_mag),
        .i_divisor  (r_total),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_limit <= POSITION_LIMIT_RST;
            r_max_span       <= MAX_SPAN_RST;
            r_lock_duration  <= LOCK_DURATION_RST;
            r_min_frames     <= MIN_FRAMES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POSITION_LIMIT:   r_position_limit <= i_cfg_data[LIMIT_BITS-1:0];
                REG_MAX_SPAN:         r_max_span       <= i_cfg_data[SPAN_BITS-1:0];
                REG_LOCK_DURATION_MS: r_lock_duration  <= i_cfg_data[DUR_BITS-1:0];
                REG_MIN_FRAMES:       r_min_frames     <= i_cfg_data[FRAME_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_pos   <= i_position;
            r_time  <= i_sample_time_ms;
            r_frame <= i_frame_number;
        end
    end

    // Sequencer, window state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_last_frame <= '0;
            r_start_ms   <= '0;
            r_total      <= '0;
            r_open       <= 1'b0;
            r_sum        <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_held       <= '0;
            r_locked     <= 1'b0;
            r_neg        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // The output register fills from the emit state and empties on a transfer.
            if (r_state == ST_EMIT && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_locked <= n_lock;
                    r_state  <= n_lock ? ST_DIV_START : ST_EMIT;
                    priority if (n_dup) begin
                        // Repeated frame: nothing changes.
                    end else if (n_oor) begin
                        r_last_frame <= r_frame;
                        r_start_ms   <= '0;
                        r_total      <= '0;
                        r_open       <= 1'b0;
                        r_sum        <= '0;
                        r_min        <= '0;
                        r_max        <= '0;
                    end else if (!r_open || n_span_big) begin
                        // Open or restart the window at this sample.
                        r_last_frame <= r_frame;
                        r_start_ms   <= r_time;
                        r_total      <= COUNT_BITS'(1);
                        r_open       <= 1'b1;
                        r_sum        <= SUM_BITS'(r_pos);
                        r_min        <= r_pos;
                        r_max        <= r_pos;
                    end else begin
                        r_last_frame <= r_frame;
                        r_min        <= n_lo;
                        r_max        <= n_hi;
                        r_total      <= n_total;
                        r_sum        <= n_sum;
                    end
                end
                ST_DIV_START: begin
                    r_neg   <= r_sum[SUM_BITS-1];
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_held  <= r_neg ? -$signed(w_quotient[POSITION_BITS-1:0])
                                         : $signed(w_quotient[POSITION_BITS-1:0]);
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output payload, loaded when the result enters the output register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && n_out_free) begin
            r_out_lock   <= r_locked;
            r_out_target <= r_held;
            r_out_span   <= r_open ? n_span_wide[SPAN_BITS-1:0] : '0;
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_lock_status     = r_out_lock;
    assign o_target_position = r_out_target;
    assign o_window_span     = r_out_span;

endmodule

`default_nettype wire
